// ===== rtl/acra_pkg.sv =====
// Shared types, codes and defaults of the alternating-category resource arbiter.
package acra_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_WIDTH_DEF    = 8;

	typedef enum logic {
		ACT_REQUEST = 1'b0,
		ACT_RELEASE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		HOLD_FREE = 2'd0,
		HOLD_ZERO = 2'd1,
		HOLD_ONE  = 2'd2
	} holder_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_REL_FREE = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} stat_t;

endpackage

// ===== rtl/acra_in_if.sv =====
// Request channel: valid/ready handshake with action, category and requester ID.
interface acra_in_if #(
	parameter int ID_WIDTH = acra_pkg::ID_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic                action;
	logic                category;
	logic [ID_WIDTH-1:0] requester_id;

	modport source (output valid, output action, output category, output requester_id,
		input ready);
	modport sink (input valid, input action, input category, input requester_id,
		output ready);
endinterface

// ===== rtl/acra_out_if.sv =====
// Result channel: valid/ready handshake with grant, holder and status fields.
interface acra_out_if #(
	parameter int ID_WIDTH = acra_pkg::ID_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic                granted;
	logic [ID_WIDTH-1:0] granted_id;
	logic                granted_category;
	logic [1:0]          holder;
	logic [1:0]          status;

	modport source (output valid, output granted, output granted_id,
		output granted_category, output holder, output status, input ready);
	modport sink (input valid, input granted, input granted_id,
		input granted_category, input holder, input status, output ready);
endinterface

// ===== rtl/acra_ctrl.sv =====
// Controller: sequences capture and execution of one request at a time.
module acra_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  acra_pkg::stat_t stat,
	output acra_pkg::cmd_t  cmd
);

	acra_pkg::state_t state_q;
	acra_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acra_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			acra_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = acra_pkg::S_EXEC;
				end
			end
			acra_pkg::S_EXEC: begin
				// hold until the result register can take the outcome
				if (!stat.out_busy) begin
					cmd.exec = 1'b1;
					state_d  = acra_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = acra_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/acra_datapath.sv =====
// Datapath: holder, two waiter FIFOs in memory, and the result register.
module acra_datapath #(
	parameter int QUEUE_DEPTH = acra_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH    = acra_pkg::ID_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  acra_pkg::cmd_t      cmd,
	output acra_pkg::stat_t     stat,
	input  logic                in_action,
	input  logic                in_category,
	input  logic [ID_WIDTH-1:0] in_id,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                out_granted,
	output logic [ID_WIDTH-1:0] out_granted_id,
	output logic                out_granted_category,
	output logic [1:0]          out_holder,
	output logic [1:0]          out_status
);

	localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
	localparam logic [HW-1:0] LAST_HEAD = HW'(QUEUE_DEPTH - 1);
	localparam logic [CW:0]   DEPTH_SUM = (CW + 1)'(QUEUE_DEPTH);

	// captured request
	logic                action_q;
	logic                cat_q;
	logic [ID_WIDTH-1:0] id_q;

	acra_pkg::holder_t   holder_q;
	logic [HW-1:0]       head0_q, head1_q;
	logic [CW-1:0]       cnt0_q, cnt1_q;

	logic [ID_WIDTH-1:0] mem0 [QUEUE_DEPTH];
	logic [ID_WIDTH-1:0] mem1 [QUEUE_DEPTH];
	logic [ID_WIDTH-1:0] rd0_q, rd1_q;

	logic                valid_q;
	logic                granted_q;
	logic [ID_WIDTH-1:0] gid_q;
	logic                gcat_q;
	acra_pkg::holder_t   oholder_q;
	acra_pkg::status_t   ostatus_q;

	// next-state decision
	logic                cur;
	logic                push, pop0, pop1;
	logic                grant;
	logic [ID_WIDTH-1:0] gid;
	logic                gcat;
	acra_pkg::holder_t   holder_d;
	acra_pkg::status_t   status_d;
	logic [HW-1:0]       push_head;
	logic [CW-1:0]       push_cnt;
	logic [CW:0]         wr_sum;
	logic [HW-1:0]       wr_addr;
	logic                wr0, wr1;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= in_action;
			cat_q    <= in_category;
			id_q     <= in_id;
		end
	end

	always_comb begin
		cur      = (holder_q == acra_pkg::HOLD_ONE);
		push     = 1'b0;
		pop0     = 1'b0;
		pop1     = 1'b0;
		grant    = 1'b0;
		gid      = '0;
		gcat     = 1'b0;
		holder_d = holder_q;
		status_d = acra_pkg::STAT_OK;
		if (action_q == acra_pkg::ACT_REQUEST) begin
			if (holder_q == acra_pkg::HOLD_FREE) begin
				grant    = 1'b1;
				gid      = id_q;
				gcat     = cat_q;
				holder_d = cat_q ? acra_pkg::HOLD_ONE : acra_pkg::HOLD_ZERO;
			end else if ((cat_q ? cnt1_q : cnt0_q) == FULL_CNT) begin
				status_d = acra_pkg::STAT_FULL;
			end else begin
				push = 1'b1;
			end
		end else begin
			if (holder_q == acra_pkg::HOLD_FREE) begin
				status_d = acra_pkg::STAT_REL_FREE;
			end else if ((cur ? cnt0_q : cnt1_q) != '0) begin
				// the other category goes first
				grant    = 1'b1;
				gcat     = !cur;
				gid      = cur ? rd0_q : rd1_q;
				pop0     = cur;
				pop1     = !cur;
				holder_d = cur ? acra_pkg::HOLD_ZERO : acra_pkg::HOLD_ONE;
			end else if ((cur ? cnt1_q : cnt0_q) != '0) begin
				grant = 1'b1;
				gcat  = cur;
				gid   = cur ? rd1_q : rd0_q;
				pop0  = !cur;
				pop1  = cur;
			end else begin
				holder_d = acra_pkg::HOLD_FREE;
			end
		end
	end

	// tail = head + count, wrapped once
	always_comb begin
		push_head = cat_q ? head1_q : head0_q;
		push_cnt  = cat_q ? cnt1_q : cnt0_q;
		wr_sum    = (CW + 1)'(push_head) + (CW + 1)'(push_cnt);
		if (wr_sum >= DEPTH_SUM) begin
			wr_sum = wr_sum - DEPTH_SUM;
		end
		wr_addr = wr_sum[HW-1:0];
		wr0     = cmd.exec && push && !cat_q;
		wr1     = cmd.exec && push && cat_q;
	end

	always_ff @(posedge clk) begin
		if (wr0) begin
			mem0[wr_addr] <= id_q;
		end
		rd0_q <= mem0[head0_q];
	end

	always_ff @(posedge clk) begin
		if (wr1) begin
			mem1[wr_addr] <= id_q;
		end
		rd1_q <= mem1[head1_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holder_q <= acra_pkg::HOLD_FREE;
			head0_q  <= '0;
			head1_q  <= '0;
			cnt0_q   <= '0;
			cnt1_q   <= '0;
		end else if (cmd.exec) begin
			holder_q <= holder_d;
			if (wr0) begin
				cnt0_q <= cnt0_q + 1'b1;
			end else if (pop0) begin
				cnt0_q  <= cnt0_q - 1'b1;
				head0_q <= (head0_q == LAST_HEAD) ? '0 : head0_q + 1'b1;
			end
			if (wr1) begin
				cnt1_q <= cnt1_q + 1'b1;
			end else if (pop1) begin
				cnt1_q  <= cnt1_q - 1'b1;
				head1_q <= (head1_q == LAST_HEAD) ? '0 : head1_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.exec) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			granted_q <= grant;
			gid_q     <= gid;
			gcat_q    <= gcat;
			oholder_q <= holder_d;
			ostatus_q <= status_d;
		end
	end

	assign stat.out_busy        = valid_q && !out_ready;
	assign out_valid            = valid_q;
	assign out_granted          = granted_q;
	assign out_granted_id       = gid_q;
	assign out_granted_category = gcat_q;
	assign out_holder           = oholder_q;
	assign out_status           = ostatus_q;

endmodule

// ===== rtl/alternating_category_resource_arbiter.sv =====
// Top level of the alternating-category resource arbiter.
//
// One shared resource is arbitrated between requesters of two categories.
// The requests channel carries action (request or release), category and
// requester_id; the results channel returns one result per request: whether
// a grant was made, the granted ID and category, the holder afterwards and
// a status (ok, queue full and dropped, release while free).
// Waiters are kept in one FIFO memory per category, QUEUE_DEPTH deep.
// A request is captured in the idle state and executed in the exec state,
// once the head entries of both FIFO memories have been read out through
// their registered read ports and the output register can take the result;
// a new request is accepted only after the previous one has executed. The
// result is loaded into the output register when the request executes.
// The output register parts the two sides: a new request is accepted while
// an earlier result still waits; if the receiver stalls, execution holds
// until that result is taken, and ready stays low meanwhile.
// Reset frees the resource and empties both FIFOs; no clearing pass is needed.
module alternating_category_resource_arbiter #(
	parameter int QUEUE_DEPTH = acra_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH    = acra_pkg::ID_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	acra_in_if.sink    requests,
	acra_out_if.source results
);

	acra_pkg::cmd_t  cmd;
	acra_pkg::stat_t stat;

	acra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (requests.valid),
		.in_ready (requests.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	acra_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_WIDTH    (ID_WIDTH)
	) u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.stat                 (stat),
		.in_action            (requests.action),
		.in_category          (requests.category),
		.in_id                (requests.requester_id),
		.out_ready            (results.ready),
		.out_valid            (results.valid),
		.out_granted          (results.granted),
		.out_granted_id       (results.granted_id),
		.out_granted_category (results.granted_category),
		.out_holder           (results.holder),
		.out_status           (results.status)
	);

endmodule

// ===== rtl/acra_checker.sv =====
// Port-level checker for the arbiter, bound to the top level.
module acra_checker #(
	parameter int ID_WIDTH = acra_pkg::ID_WIDTH_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic                granted,
	input logic [ID_WIDTH-1:0] granted_id,
	input logic [1:0]          holder,
	input logic [1:0]          status
);

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(granted_id) && $stable(holder))
		else $error("result changed while stalled");

	// one request in flight: ready drops after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another executes");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted |-> holder != acra_pkg::HOLD_FREE)
		else $error("grant left the resource free");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == acra_pkg::STAT_REL_FREE |->
		!granted && holder == acra_pkg::HOLD_FREE)
		else $error("release while free changed state");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == acra_pkg::STAT_FULL |->
		!granted && holder != acra_pkg::HOLD_FREE)
		else $error("dropped request granted or freed resource");

endmodule

bind alternating_category_resource_arbiter acra_checker #(
	.ID_WIDTH (ID_WIDTH)
) u_acra_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (requests.valid),
	.in_ready   (requests.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.granted    (results.granted),
	.granted_id (results.granted_id),
	.holder     (results.holder),
	.status     (results.status)
);
